// ===== hdl/iatan_pkg.sv =====
// iatan_pkg: widths, constants, correction table and side-band struct for the
// integer bearing pipeline. No dependencies.
`default_nettype none

package iatan_pkg;

  // input field width (valid range 8..20)
  localparam int unsigned InW         = 16;
  // Q10 octant scale: 1 << AngBits stands for 45 degrees
  localparam int unsigned AngBits     = 10;
  localparam int unsigned OutW        = 9;
  localparam int unsigned DegPerOct   = 45;

  // divider: numerator magnitude never exceeds the denominator
  localparam int unsigned DivW        = InW + 1;
  localparam int unsigned QuoW        = AngBits + 1;
  localparam int unsigned StepsPerStg = 2;
  localparam int unsigned DivStg      = (QuoW + StepsPerStg - 1) / StepsPerStg;

  // coarse angle 0..4 octants, unsigned, then signed after correction
  localparam int unsigned AngUW       = AngBits + 3;
  localparam int unsigned AngW        = AngUW + 1;
  localparam int unsigned ProdW       = AngW + 7;
  localparam int unsigned TabBits     = 5;
  localparam int unsigned TabW        = 8;
  localparam int unsigned Rnd         = (1 << (AngBits - 1)) / DegPerOct;

  typedef struct packed {
    logic zero;     // both inputs zero
    logic y_neg;
    logic x_neg;
    logic num_neg;  // sign of the quotient
  } side_t;

  function automatic logic signed [TabW-1:0] fix_lut(input logic [TabBits-1:0] idx);
    logic signed [TabW-1:0] v;
    case (idx)
      5'd0:    v = 8'sd0;
      5'd1:    v = -8'sd23;
      5'd2:    v = -8'sd42;
      5'd3:    v = -8'sd59;
      5'd4:    v = -8'sd72;
      5'd5:    v = -8'sd83;
      5'd6:    v = -8'sd89;
      5'd7:    v = -8'sd92;
      5'd8:    v = -8'sd92;
      5'd9:    v = -8'sd88;
      5'd10:   v = -8'sd81;
      5'd11:   v = -8'sd71;
      5'd12:   v = -8'sd58;
      5'd13:   v = -8'sd43;
      5'd14:   v = -8'sd27;
      5'd15:   v = -8'sd9;
      5'd16:   v = 8'sd9;
      5'd17:   v = 8'sd27;
      5'd18:   v = 8'sd43;
      5'd19:   v = 8'sd58;
      5'd20:   v = 8'sd71;
      5'd21:   v = 8'sd81;
      5'd22:   v = 8'sd88;
      5'd23:   v = 8'sd92;
      5'd24:   v = 8'sd92;
      5'd25:   v = 8'sd89;
      5'd26:   v = 8'sd83;
      5'd27:   v = 8'sd72;
      5'd28:   v = 8'sd59;
      5'd29:   v = 8'sd42;
      5'd30:   v = 8'sd23;
      5'd31:   v = 8'sd0;
      default: v = 8'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_atan2_degrees.sv =====
// integer_atan2_degrees: pipelined bearing of a signed (x, y) pair in whole
// degrees. Depends on iatan_pkg (widths, correction table, side_t).
//
//  channel  | signals                           | dir | transaction
//  ---------+-----------------------------------+-----+------------------------------
//  command  | start, busy, coord_y_i, coord_x_i | in  | edge with start high, busy low
//  result   | done_o, bearing_degrees_o         | out | one-cycle strobe on done_o
//
// One pair may enter every cycle; busy is never raised. DivStg + 3 register
// stages (9 at the default widths): an input register, DivStg divider stages
// of up to StepsPerStg restoring steps each, a correction stage and a
// scale/negate stage feeding the output register; the divider stages set the
// depth. Reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so nothing in the pipe ever waits.
`default_nettype none

module integer_atan2_degrees (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [iatan_pkg::InW-1:0]  coord_y_i,
  input  wire logic signed [iatan_pkg::InW-1:0]  coord_x_i,
  output logic                                   done_o,
  output logic signed [iatan_pkg::OutW-1:0]      bearing_degrees_o
);

  import iatan_pkg::*;

  // ------------------------------------------------------------------
  // Stage 0: magnitudes, numerator and denominator of the octant ratio.
  // x >= 0: (x - |y|) / (x + |y|);  x < 0: (x + |y|) / (|y| - x).
  // ------------------------------------------------------------------
  logic signed [InW+1:0] ys, xs, ay, num, den_s, numa;
  side_t                 side0_d;

  always_comb begin
    ys = (InW+2)'(coord_y_i);
    xs = (InW+2)'(coord_x_i);
    ay = ys[InW+1] ? -ys : ys;
    if (!xs[InW+1]) begin
      num   = xs - ay;
      den_s = xs + ay;
    end else begin
      num   = xs + ay;
      den_s = ay - xs;
    end
    numa            = num[InW+1] ? -num : num;
    side0_d.zero    = (coord_x_i == '0) && (coord_y_i == '0);
    side0_d.y_neg   = coord_y_i[InW-1];
    side0_d.x_neg   = coord_x_i[InW-1];
    side0_d.num_neg = num[InW+1];
  end

  // pipeline arrays: index 0 is the input register, 1..DivStg the divider
  logic            valid_q [DivStg+1];
  side_t           side_q  [DivStg+1];
  logic [DivW-1:0] rem_q   [DivStg+1];
  logic [DivW-1:0] den_q   [DivStg+1];
  logic [QuoW-1:0] quo_q   [DivStg+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side0_d;
    rem_q[0]  <= numa[DivW-1:0];
    den_q[0]  <= den_s[DivW-1:0];
    quo_q[0]  <= '0;
  end

  // ------------------------------------------------------------------
  // Divider: restoring, one quotient bit per step, MSB (integer bit) first.
  // The first step compares without doubling since |num| <= den.
  // ------------------------------------------------------------------
  for (genvar s = 1; s <= DivStg; s++) begin : g_div
    logic [DivW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;
    logic [DivW:0]   trial;

    always_comb begin
      rem_d = rem_q[s-1];
      quo_d = quo_q[s-1];
      trial = '0;
      for (int k = 0; k < StepsPerStg; k++) begin
        if ((s - 1) * StepsPerStg + k < QuoW) begin
          if ((s - 1) * StepsPerStg + k == 0) begin
            trial = {1'b0, rem_d};
          end else begin
            trial = {rem_d, 1'b0};
          end
          if (trial >= {1'b0, den_q[s-1]}) begin
            trial = trial - {1'b0, den_q[s-1]};
            quo_d = {quo_d[QuoW-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[QuoW-2:0], 1'b0};
          end
          rem_d = trial[DivW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s] <= side_q[s-1];
      den_q[s]  <= den_q[s-1];
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
    end
  end

  // ------------------------------------------------------------------
  // Correction stage: coarse angle, table lookup, corrected angle.
  // ------------------------------------------------------------------
  localparam logic [AngUW-1:0] Base1 = AngUW'(1 << AngBits);
  localparam logic [AngUW-1:0] Base3 = AngUW'(3 << AngBits);

  logic [AngUW-1:0]       ang, ang_rnd, base;
  logic [TabBits-1:0]     idx;
  logic signed [AngW-1:0] corr_d, corr_q;
  logic                   valid_c_q;
  side_t                  side_c_q;

  always_comb begin
    base    = side_q[DivStg].x_neg ? Base3 : Base1;
    ang     = side_q[DivStg].num_neg ? base + AngUW'(quo_q[DivStg])
                                     : base - AngUW'(quo_q[DivStg]);
    ang_rnd = ang + AngUW'(Rnd);
    // index wraps modulo the table size
    idx     = ang_rnd[AngBits:AngBits-TabBits+1];
    corr_d  = $signed({1'b0, ang}) + AngW'(fix_lut(idx));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_q[DivStg];
    end
  end

  always_ff @(posedge clk_i) begin
    corr_q   <= corr_d;
    side_c_q <= side_q[DivStg];
  end

  // ------------------------------------------------------------------
  // Scale stage: degrees = floor((ang*45 + 512) / 1024), sign from y, zero for (0, 0).
  // ------------------------------------------------------------------
  localparam int unsigned Half = 1 << (AngBits - 1);

  logic signed [ProdW-1:0] prod, shifted;
  logic signed [OutW-1:0]  deg, bearing_d, bearing_q;
  logic                    done_q;

  always_comb begin
    prod    = ProdW'(corr_q) * $signed(ProdW'(DegPerOct)) + $signed(ProdW'(Half));
    shifted = prod >>> AngBits;
    deg     = shifted[OutW-1:0];
    if (side_c_q.zero) begin
      bearing_d = '0;
    end else if (side_c_q.y_neg) begin
      bearing_d = -deg;
    end else begin
      bearing_d = deg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
  end

  assign busy              = 1'b0;
  assign done_o            = done_q;
  assign bearing_degrees_o = bearing_q;

endmodule

`default_nettype wire
